// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on every clock edge outside reset.
`define PAFS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the same edge.
`define PAFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked on the next edge.
`define PAFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pafs_pkg.sv =====
// Shared constants and types of the particle age, advect and fade step.
package pafs_pkg;
	localparam int unsigned IN_DATA_W  = 440;
	localparam int unsigned OUT_DATA_W = 424;

	// Output beat field offsets.
	localparam int unsigned OFS_ALPHA = 352;
	localparam int unsigned OFS_RED   = 369;
	localparam int unsigned OFS_GREEN = 386;
	localparam int unsigned OFS_BLUE  = 403;

	localparam logic [16:0] ONE_Q16        = 17'd65536;
	localparam logic [16:0] DRAG_FLOOR_Q16 = 17'd13107;
	localparam logic [16:0] EMIS_GREEN_Q16 = 17'd62259;
	localparam logic [16:0] EMIS_BLUE_Q16  = 17'd52429;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_STREAM_ACTIVE = 2'd0,
		REG_EMISSIVE_MODE = 2'd1,
		REG_GROWTH_RATE   = 2'd2,
		REG_SLOWDOWN_RATE = 2'd3
	} reg_idx_t;

	// Particle record carried along the pipeline.
	typedef struct packed {
		logic [2:0][63:0] pos;
		logic [2:0][31:0] vel;
		logic [31:0]      size;
		logic [31:0]      age;
		logic [16:0]      alpha;
		logic             active;
		logic             emis;
	} rec_t;
endpackage

// ===== sv/pafs_div.sv =====
// Pipelined restoring divider giving a 16-bit fraction of num / den with num below den.
module pafs_div #(
	parameter int unsigned DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [31:0]   num,
	input  logic [31:0]   den,
	input  logic [DW-1:0] in_data,
	output logic          out_valid,
	output logic [15:0]   quo,
	output logic [DW-1:0] out_data
);
	localparam int unsigned STEPS = 16;

	logic              v_q   [0:STEPS];
	logic [31:0]       r_q   [0:STEPS];
	logic [31:0]       d_q   [0:STEPS];
	logic [15:0]       q_q   [0:STEPS];
	logic [DW-1:0]     dat_q [0:STEPS];

	// Stage zero is the input itself.
	assign v_q[0]   = in_valid;
	assign r_q[0]   = num;
	assign d_q[0]   = den;
	assign q_q[0]   = '0;
	assign dat_q[0] = in_data;

	// One quotient bit per stage, most significant first.
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic [32:0] r2;
		logic        ge;
		assign r2 = {r_q[k-1], 1'b0};
		assign ge = r2 >= {1'b0, d_q[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (en) begin
				v_q[k] <= v_q[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]   <= ge ? 32'(r2 - {1'b0, d_q[k-1]}) : r2[31:0];
				d_q[k]   <= d_q[k-1];
				q_q[k]   <= {q_q[k-1][14:0], ge};
				dat_q[k] <= dat_q[k-1];
			end
		end
	end

	assign out_valid = v_q[STEPS];
	assign quo       = q_q[STEPS];
	assign out_data  = dat_q[STEPS];
endmodule

// ===== sv/particle_age_advect_fade_step_top.sv =====
// Top level of the particle age, advect and fade step pipeline.
// Takes one particle record per beat and gives at most one updated record per beat, one
// record per cycle while the output is not stalled. A record passes 23 register stages:
// four input and arithmetic stages, a sixteen-stage restoring divider for normalized age,
// two fade stages and the output register.
// Dead particles leave a bubble and no beat.
// The whole pipeline advances whenever the output register is empty or being taken.
module particle_age_advect_fade_step_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_idx,
	input  logic [31:0]                       cfg_data,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, puff_size, age_in, life_span,
	// base_alpha, time_step, zero fill
	input  logic [pafs_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z, new_size,
	// age_out, fade_alpha, tint_red, tint_green, tint_blue, zero fill
	output logic [pafs_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
	import pafs_pkg::*;

	logic        active_q, emis_q;
	logic [31:0] growth_q, slow_q;
	logic        en;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			emis_q   <= 1'b0;
			growth_q <= '0;
			slow_q   <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_STREAM_ACTIVE: active_q <= cfg_data[0];
				REG_EMISSIVE_MODE: emis_q   <= cfg_data[0];
				REG_GROWTH_RATE:   growth_q <= cfg_data;
				REG_SLOWDOWN_RATE: slow_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Stage 1: register the input beat.
	rec_t        rec_s1;
	logic [31:0] life_s1, dt_s1;
	logic        v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_s1.pos    <= s_axis_tdata[191:0];
			rec_s1.vel    <= s_axis_tdata[287:192];
			rec_s1.size   <= s_axis_tdata[319:288];
			rec_s1.age    <= s_axis_tdata[351:320];
			life_s1       <= s_axis_tdata[383:352];
			rec_s1.alpha  <= s_axis_tdata[400:384];
			dt_s1         <= s_axis_tdata[432:401];
			rec_s1.active <= active_q;
			rec_s1.emis   <= emis_q;
		end
	end

	// Stage 2: advance age, drop dead particles, form the step products.
	logic [32:0] age_sum;
	logic [31:0] age_adv;
	logic        alive_s1;
	assign age_sum  = {1'b0, rec_s1.age} + 33'(dt_s1[31:8]);
	assign age_adv  = rec_s1.active ? (age_sum[32] ? '1 : age_sum[31:0]) : rec_s1.age;
	assign alive_s1 = !rec_s1.active || (age_adv < life_s1);

	rec_t               rec_s2;
	logic [31:0]        life_s2;
	logic               v_s2;
	logic signed [64:0] disp_p_s2 [3];
	logic [63:0]        grow_p_s2, slow_p_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1 && alive_s1;
	end

	always_ff @(posedge clk) begin
		rec_t nxt2;
		if (en) begin
			nxt2     = rec_s1;
			nxt2.age = age_adv;
			rec_s2   <= nxt2;
			life_s2  <= life_s1;
			for (int i = 0; i < 3; i++) begin
				disp_p_s2[i] <= 65'($signed(rec_s1.vel[i])) * 65'($signed({1'b0, dt_s1}));
			end
			grow_p_s2 <= 64'(growth_q) * 64'(dt_s1);
			slow_p_s2 <= 64'(slow_q) * 64'(dt_s1);
		end
	end

	// Stage 3: saturating position and size updates, drag factor.
	logic [63:0] pos_n [3];
	logic [31:0] size_n;
	logic [16:0] drag_n;
	always_comb begin
		logic signed [64:0] disp, sum;
		logic [40:0]        gsum;
		logic [39:0]        s;
		logic [16:0]        d;
		for (int i = 0; i < 3; i++) begin
			disp = disp_p_s2[i] >>> 24;
			sum  = 65'($signed(rec_s2.pos[i])) + disp;
			if (!rec_s2.active) pos_n[i] = rec_s2.pos[i];
			else if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) pos_n[i] = 64'h7FFF_FFFF_FFFF_FFFF;
			else if (sum < -65'sh0_8000_0000_0000_0000) pos_n[i] = 64'h8000_0000_0000_0000;
			else pos_n[i] = sum[63:0];
		end
		gsum = {9'd0, rec_s2.size} + 41'(grow_p_s2[63:24]);
		if (!rec_s2.active) size_n = rec_s2.size;
		else size_n = (gsum > 41'h0_FFFF_FFFF) ? '1 : gsum[31:0];
		s = slow_p_s2[63:24];
		d = (s >= 40'(ONE_Q16)) ? 17'd0 : 17'(40'(ONE_Q16) - s);
		if (d < DRAG_FLOOR_Q16) d = DRAG_FLOOR_Q16;
		drag_n = rec_s2.active ? d : ONE_Q16;
	end

	rec_t        rec_s3;
	logic [31:0] life_s3;
	logic [16:0] drag_s3;
	logic        v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		rec_t nxt3;
		if (en) begin
			nxt3 = rec_s2;
			for (int i = 0; i < 3; i++) nxt3.pos[i] = pos_n[i];
			nxt3.size = size_n;
			rec_s3    <= nxt3;
			life_s3   <= life_s2;
			drag_s3   <= drag_n;
		end
	end

	// Stage 4: scale velocity by drag.
	rec_t        rec_s4;
	logic [31:0] life_s4;
	logic        v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		logic signed [49:0] pv;
		rec_t               nxt4;
		if (en) begin
			nxt4 = rec_s3;
			for (int i = 0; i < 3; i++) begin
				pv = 50'($signed(rec_s3.vel[i])) * 50'($signed({1'b0, drag_s3}));
				nxt4.vel[i] = 32'(pv >>> 16);
			end
			rec_s4  <= nxt4;
			life_s4 <= life_s3;
		end
	end

	// Normalized age t = age / life in Q0.16.
	logic        v_dv;
	logic [15:0] t_dv;
	rec_t        rec_dv;

	pafs_div #(.DW($bits(rec_t))) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.num      (rec_s4.age),
		.den      (life_s4),
		.in_data  (rec_s4),
		.out_valid(v_dv),
		.quo      (t_dv),
		.out_data (rec_dv)
	);

	// Fade stage 1: fade-in, fade-out and diffuse grey from t.
	logic [16:0] fin_n, fout_n, grey_n;
	always_comb begin
		logic [20:0] x20;
		logic [40:0] m3;
		logic [18:0] x5, y5;
		logic [19:0] x11;
		logic [35:0] m5;
		x20   = 21'(t_dv) * 21'd20;
		m3    = 41'(x20) * 41'd349526;
		fin_n = (x20 < 21'd196608) ? m3[36:20] : ONE_Q16;
		x5    = 19'(t_dv) * 19'd5;
		y5    = 19'(ONE_Q16 - 17'(t_dv)) * 19'd5;
		fout_n = (x5 > 19'd196608) ? y5[17:1] : ONE_Q16;
		x11   = 20'(t_dv) * 20'd11;
		m5    = 36'(x11[19:2]) * 36'd209716;
		grey_n = ONE_Q16 - 17'(m5[35:20]);
	end

	rec_t        rec_f1;
	logic [16:0] fin_f1, fout_f1, grey_f1;
	logic        tz_f1, v_f1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f1 <= 1'b0;
		else if (en) v_f1 <= v_dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_f1  <= rec_dv;
			fin_f1  <= fin_n;
			fout_f1 <= fout_n;
			grey_f1 <= grey_n;
			tz_f1   <= (t_dv == '0);
		end
	end

	// Fade stage 2: life curve.
	rec_t        rec_f2;
	logic [16:0] curve_f2, grey_f2;
	logic        v_f2;
	logic [33:0] cprod;
	assign cprod = 34'(fin_f1) * 34'(fout_f1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_f2 <= 1'b0;
		else if (en) v_f2 <= v_f1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rec_f2   <= rec_f1;
			curve_f2 <= tz_f1 ? 17'd0 : cprod[32:16];
			grey_f2  <= grey_f1;
		end
	end

	// Alpha and tint, formed in front of the output register.
	logic [16:0] a_clamp, alpha_n, red_n, green_n, blue_n;
	logic [33:0] aprod;
	assign a_clamp = (rec_f2.alpha > ONE_Q16) ? ONE_Q16 : rec_f2.alpha;
	assign aprod   = 34'(a_clamp) * 34'(curve_f2);

	always_comb begin
		if (rec_f2.emis) begin
			red_n   = ONE_Q16;
			green_n = EMIS_GREEN_Q16;
			blue_n  = EMIS_BLUE_Q16;
		end else if (rec_f2.active) begin
			red_n   = grey_f2;
			green_n = grey_f2;
			blue_n  = grey_f2;
		end else begin
			red_n   = ONE_Q16;
			green_n = ONE_Q16;
			blue_n  = ONE_Q16;
		end
		alpha_n = rec_f2.active ? aprod[32:16] : rec_f2.alpha;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_axis_tvalid <= 1'b0;
		else if (en) m_axis_tvalid <= v_f2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= {4'd0, blue_n, green_n, red_n, alpha_n, rec_f2.age,
				rec_f2.size, rec_f2.vel, rec_f2.pos};
		end
	end
endmodule

// ===== sv/pafs_checker.sv =====
// Port-level checker for the particle step top level, with its bind.
`include "assert_macros.svh"

module pafs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [pafs_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
	import pafs_pkg::*;

	// A waiting beat stays and holds its data.
	`PAFS_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "out beat dropped")
	`PAFS_ASSERT_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "out data moved")
	// The pipeline moves whenever the output register is free.
	`PAFS_ASSERT_IMP(a_ready, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input stalled")
	// Red tint never exceeds one.
	`PAFS_ASSERT_IMP(a_red, m_axis_tvalid, m_axis_tdata[OFS_GREEN-1:OFS_RED] <= ONE_Q16, "red out of range")
endmodule

bind particle_age_advect_fade_step_top pafs_checker u_pafs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);
